[rtl/whqi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whqi_pkg
// Shared types and constants of the weighted histogram quantile interval unit.
// ----------------------------------------------------------------------------
package whqi_pkg;

  localparam int CFG_W         = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int BIN_COUNT_W   = 17;
  localparam int COVERAGE_W    = 16;
  localparam int TOTAL_W       = 64;
  localparam int THR_W         = 82;
  localparam int KIND_W        = 3;

  localparam logic [30:0] RANGE_LOW_RST = 31'd105000;
  localparam logic [16:0] BIN_COUNT_RST = 17'd55000;
  localparam logic [30:0] CENTER_RST    = 31'd125000;
  localparam logic [15:0] COVERAGE_RST  = 16'd44760;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FINISH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_RANGE_LOW = 2'd0,
    REG_BIN_COUNT = 2'd1,
    REG_CENTER    = 2'd2,
    REG_COVERAGE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_TOTAL   = 3'd0,
    KIND_TAIL_L  = 3'd1,
    KIND_TAIL_R  = 3'd2,
    KIND_CENT_L  = 3'd3,
    KIND_CENT_R  = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLR_INIT,
    DP_CLR_STEP,
    DP_LATCH,
    DP_ADD_RD,
    DP_ADD_WR,
    DP_MUL_T,
    DP_SUM_T,
    DP_MUL_F,
    DP_SUM_F,
    DP_EMIT_TOTAL,
    DP_T_INIT,
    DP_T_RD,
    DP_T_ACC,
    DP_C_INIT,
    DP_C_SEED,
    DP_C_TEST,
    DP_C_ACC,
    DP_C_EML,
    DP_C_EMR
  } dp_cmd_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_MUL_T,
    ST_SUM_T,
    ST_MUL_F,
    ST_SUM_F,
    ST_TOTAL,
    ST_TL_INIT,
    ST_TL_RD,
    ST_TL_ACC,
    ST_TR_INIT,
    ST_TR_RD,
    ST_TR_ACC,
    ST_C_INIT,
    ST_C_SEED,
    ST_C_ACC,
    ST_C_TEST,
    ST_C_EML,
    ST_C_EMR
  } ctrl_state_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    tail_right;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic seed_ok;
    logic t_end;
    logic t_hit;
    logic c_less;
    logic c_edge;
  } sts_t;

endpackage

[rtl/whqi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whqi_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module whqi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/whqi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whqi_datapath
// Configuration, bin memory, running total, thresholds and the bin walks.
// ----------------------------------------------------------------------------
module whqi_datapath
  import whqi_pkg::*;
#(
  parameter int MAX_BINS     = 65536,
  parameter int BIN_SUM_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  output sts_t                 sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [31:0]          sample_value_i,
  input  logic [31:0]          sample_weight_i,
  output logic                 result_valid_o,
  output logic [KIND_W-1:0]    kind_o,
  output logic [63:0]          result_value_o,
  output logic                 found_o,
  output logic                 last_o
);

  localparam int AW    = $clog2(MAX_BINS);
  localparam int NW    = AW + 1;
  localparam int ACC_W = BIN_SUM_BITS + AW + 1;
  localparam int CMP_W = ((ACC_W + 17) > THR_W ? (ACC_W + 17) : THR_W) + 1;
  localparam int CW    = (NW > BIN_COUNT_W) ? NW : BIN_COUNT_W;

  logic [30:0]             range_low_q;
  logic [BIN_COUNT_W-1:0]  bin_count_q;
  logic [30:0]             center_q;
  logic [COVERAGE_W-1:0]   coverage_q;
  logic [TOTAL_W-1:0]      total_q;
  logic [AW-1:0]           clr_addr_q;
  logic                    out_valid_q, out_valid_d;

  logic [AW-1:0]           idx_q;
  logic                    add_ok_q;
  logic [31:0]             w_q;
  logic [48:0]             plo_q;
  logic signed [49:0]      phi_q;
  logic signed [THR_W-1:0] tail_q, frac_q;
  logic [NW-1:0]           p_q;
  logic [AW-1:0]           a_q, b_q;
  logic                    wl_q, c_ok_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [KIND_W-1:0]       kind_q;
  logic [63:0]             val_q;
  logic                    found_q, last_q;

  logic [CW-1:0]           bc_ext, n_full;
  logic [NW-1:0]           n;
  logic signed [32:0]      diff;
  logic                    add_in_range;
  logic [31:0]             c_diff;
  logic                    seed_ok;
  logic [BIN_SUM_BITS-1:0] rdata;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [CMP_W-1:0] an_ext, ac_ext, tail_ext, frac_ext;
  logic                    t_end, t_hit, c_less, c_edge, wl_n;
  logic [AW-1:0]           raddr, waddr;
  logic                    we;
  logic [BIN_SUM_BITS-1:0] wdata;
  logic [16:0]             mul_m;
  logic [48:0]             plo_d;
  logic signed [49:0]      phi_d;
  logic signed [THR_W-1:0] thr_d;
  logic [63:0]             pos_p, pos_l, pos_r;
  logic [NW-1:0]           b_inc;

  // bins in use, clamped to the memory depth
  always_comb begin
    bc_ext = CW'(bin_count_q);
    n_full = (bc_ext > CW'(MAX_BINS)) ? CW'(MAX_BINS) : bc_ext;
    n      = NW'(n_full);
  end

  assign diff         = $signed({sample_value_i[31], sample_value_i})
                      - $signed({2'b00, range_low_q});
  assign add_in_range = !diff[32] && (diff[31:0] < 32'(n));
  assign c_diff       = {1'b0, center_q} - {1'b0, range_low_q};
  assign seed_ok      = !c_diff[31] && (c_diff[30:0] < 31'(n));

  assign acc_next = acc_q + ACC_W'($signed(rdata));
  assign an_ext   = CMP_W'(acc_next) <<< 17;
  assign ac_ext   = CMP_W'(acc_q) <<< 16;
  assign tail_ext = CMP_W'(tail_q);
  assign frac_ext = CMP_W'(frac_q);
  assign t_hit    = tail_ext < an_ext;
  assign c_less   = ac_ext < frac_ext;
  assign t_end    = ctl_i.tail_right ? (p_q == '0) : (p_q == n);
  assign wl_n     = !wl_q;
  assign b_inc    = NW'(b_q) + NW'(1);
  assign c_edge   = wl_n ? (a_q == '0) : (b_inc >= n);

  assign sts_o = '{clr_last: (clr_addr_q == AW'(MAX_BINS - 1)),
                   seed_ok:  seed_ok,
                   t_end:    t_end,
                   t_hit:    t_hit,
                   c_less:   c_less,
                   c_edge:   c_edge};

  always_comb begin
    unique case (ctl_i.cmd)
      DP_ADD_RD: raddr = idx_q;
      DP_T_RD:   raddr = ctl_i.tail_right ? AW'(p_q - NW'(1)) : AW'(p_q);
      DP_C_SEED: raddr = a_q;
      DP_C_TEST: raddr = wl_n ? (a_q - AW'(1)) : AW'(b_inc);
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr_q;
    wdata = '0;
    if (ctl_i.cmd == DP_CLR_STEP) begin
      we = 1'b1;
    end else if (ctl_i.cmd == DP_ADD_WR) begin
      we    = add_ok_q;
      waddr = idx_q;
      wdata = rdata + BIN_SUM_BITS'($signed(w_q));
    end
  end

  whqi_ram #(
    .WIDTH (BIN_SUM_BITS),
    .DEPTH (MAX_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // total times a 17-bit factor, split in two 32-bit halves
  assign mul_m = (ctl_i.cmd == DP_MUL_T) ? (17'h10000 - 17'(coverage_q)) : 17'(coverage_q);
  assign plo_d = 49'(total_q[31:0]) * 49'(mul_m);
  assign phi_d = $signed(50'($signed(total_q[63:32]))) * $signed(50'(mul_m));
  assign thr_d = (THR_W'(phi_q) <<< 32) + $signed({{(THR_W-49){1'b0}}, plo_q});

  assign pos_p = 64'(range_low_q) + 64'(p_q);
  assign pos_l = 64'(range_low_q) + (wl_q ? (64'(a_q) + 64'd1) : 64'(a_q));
  assign pos_r = 64'(range_low_q) + (wl_q ? (64'(b_q) + 64'd1) : 64'(b_q));

  always_comb begin
    unique case (ctl_i.cmd) inside
      DP_EMIT_TOTAL, DP_C_EML, DP_C_EMR: out_valid_d = 1'b1;
      DP_T_RD:  out_valid_d = t_end;
      DP_T_ACC: out_valid_d = t_hit;
      default:  out_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q <= RANGE_LOW_RST;
      bin_count_q <= BIN_COUNT_RST;
      center_q    <= CENTER_RST;
      coverage_q  <= COVERAGE_RST;
      total_q     <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_RANGE_LOW: range_low_q <= cfg_data_i;
          REG_BIN_COUNT: bin_count_q <= cfg_data_i[BIN_COUNT_W-1:0];
          REG_CENTER:    center_q    <= cfg_data_i;
          REG_COVERAGE:  coverage_q  <= cfg_data_i[COVERAGE_W-1:0];
          default:       ;
        endcase
      end
      if (ctl_i.cmd == DP_CLR_INIT) begin
        clr_addr_q <= '0;
        total_q    <= '0;
      end else if (ctl_i.cmd == DP_CLR_STEP) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end else if (ctl_i.cmd == DP_ADD_WR && add_ok_q) begin
        total_q <= total_q + TOTAL_W'($signed(w_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd) inside
      DP_LATCH: begin
        idx_q    <= diff[AW-1:0];
        add_ok_q <= add_in_range;
        w_q      <= sample_weight_i;
      end
      DP_MUL_T, DP_MUL_F: begin
        plo_q <= plo_d;
        phi_q <= phi_d;
      end
      DP_SUM_T: tail_q <= thr_d;
      DP_SUM_F: frac_q <= thr_d;
      DP_EMIT_TOTAL: begin
        kind_q  <= KIND_TOTAL;
        val_q   <= total_q;
        found_q <= 1'b1;
        last_q  <= 1'b0;
      end
      DP_T_INIT: begin
        p_q   <= ctl_i.tail_right ? n : '0;
        acc_q <= '0;
      end
      DP_T_RD: begin
        kind_q  <= ctl_i.tail_right ? KIND_TAIL_R : KIND_TAIL_L;
        val_q   <= '0;
        found_q <= 1'b0;
        last_q  <= 1'b0;
      end
      DP_T_ACC: begin
        acc_q   <= acc_next;
        kind_q  <= ctl_i.tail_right ? KIND_TAIL_R : KIND_TAIL_L;
        val_q   <= pos_p;
        found_q <= 1'b1;
        last_q  <= 1'b0;
        if (!t_hit) begin
          p_q <= ctl_i.tail_right ? (p_q - NW'(1)) : (p_q + NW'(1));
        end
      end
      DP_C_INIT: begin
        a_q    <= c_diff[AW-1:0];
        b_q    <= c_diff[AW-1:0];
        wl_q   <= 1'b1;
        c_ok_q <= seed_ok;
        acc_q  <= '0;
      end
      DP_C_ACC: acc_q <= acc_next;
      DP_C_TEST: begin
        if (c_less) begin
          wl_q <= wl_n;
          if (c_edge) begin
            c_ok_q <= 1'b0;
          end else if (wl_n) begin
            a_q <= a_q - AW'(1);
          end else begin
            b_q <= AW'(b_inc);
          end
        end
      end
      DP_C_EML: begin
        kind_q  <= KIND_CENT_L;
        val_q   <= c_ok_q ? pos_l : '0;
        found_q <= c_ok_q;
        last_q  <= 1'b0;
      end
      DP_C_EMR: begin
        kind_q  <= KIND_CENT_R;
        val_q   <= c_ok_q ? pos_r : '0;
        found_q <= c_ok_q;
        last_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign result_valid_o = out_valid_q;
  assign kind_o         = kind_q;
  assign result_value_o = val_q;
  assign found_o        = found_q;
  assign last_o         = last_q;

endmodule

[rtl/whqi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whqi_ctrl
// Sequencer: clearing sweep, add read-modify-write and the finish walks.
// ----------------------------------------------------------------------------
module whqi_ctrl
  import whqi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] operation_i,
  output logic       busy_o,
  input  sts_t       sts_i,
  output ctl_t       ctl_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) begin
          if (operation_i == OP_ADD) state_d = ST_ADD_RD;
          else if (operation_i == OP_FINISH) state_d = ST_MUL_T;
          else if (operation_i == OP_CLEAR) state_d = ST_CLEAR;
        end
      end
      ST_ADD_RD:  state_d = ST_ADD_WR;
      ST_ADD_WR:  state_d = ST_IDLE;
      ST_MUL_T:   state_d = ST_SUM_T;
      ST_SUM_T:   state_d = ST_MUL_F;
      ST_MUL_F:   state_d = ST_SUM_F;
      ST_SUM_F:   state_d = ST_TOTAL;
      ST_TOTAL:   state_d = ST_TL_INIT;
      ST_TL_INIT: state_d = ST_TL_RD;
      ST_TL_RD:   state_d = sts_i.t_end ? ST_TR_INIT : ST_TL_ACC;
      ST_TL_ACC:  state_d = sts_i.t_hit ? ST_TR_INIT : ST_TL_RD;
      ST_TR_INIT: state_d = ST_TR_RD;
      ST_TR_RD:   state_d = sts_i.t_end ? ST_C_INIT : ST_TR_ACC;
      ST_TR_ACC:  state_d = sts_i.t_hit ? ST_C_INIT : ST_TR_RD;
      ST_C_INIT:  state_d = sts_i.seed_ok ? ST_C_SEED : ST_C_EML;
      ST_C_SEED:  state_d = ST_C_ACC;
      ST_C_ACC:   state_d = ST_C_TEST;
      ST_C_TEST:  state_d = (sts_i.c_less && !sts_i.c_edge) ? ST_C_ACC : ST_C_EML;
      ST_C_EML:   state_d = ST_C_EMR;
      ST_C_EMR:   state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.cmd        = DP_NOP;
    ctl_o.tail_right = (state_q == ST_TR_INIT) || (state_q == ST_TR_RD)
                    || (state_q == ST_TR_ACC);
    unique case (state_q) inside
      ST_CLEAR: ctl_o.cmd = DP_CLR_STEP;
      ST_IDLE: begin
        if (start_i && operation_i == OP_ADD) ctl_o.cmd = DP_LATCH;
        else if (start_i && operation_i == OP_CLEAR) ctl_o.cmd = DP_CLR_INIT;
      end
      ST_ADD_RD:  ctl_o.cmd = DP_ADD_RD;
      ST_ADD_WR:  ctl_o.cmd = DP_ADD_WR;
      ST_MUL_T:   ctl_o.cmd = DP_MUL_T;
      ST_SUM_T:   ctl_o.cmd = DP_SUM_T;
      ST_MUL_F:   ctl_o.cmd = DP_MUL_F;
      ST_SUM_F:   ctl_o.cmd = DP_SUM_F;
      ST_TOTAL:   ctl_o.cmd = DP_EMIT_TOTAL;
      ST_TL_INIT, ST_TR_INIT: ctl_o.cmd = DP_T_INIT;
      ST_TL_RD, ST_TR_RD:     ctl_o.cmd = DP_T_RD;
      ST_TL_ACC, ST_TR_ACC:   ctl_o.cmd = DP_T_ACC;
      ST_C_INIT:  ctl_o.cmd = DP_C_INIT;
      ST_C_SEED:  ctl_o.cmd = DP_C_SEED;
      ST_C_ACC:   ctl_o.cmd = DP_C_ACC;
      ST_C_TEST:  ctl_o.cmd = DP_C_TEST;
      ST_C_EML:   ctl_o.cmd = DP_C_EML;
      ST_C_EMR:   ctl_o.cmd = DP_C_EMR;
      default:    ctl_o.cmd = DP_NOP;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  a_clear_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && sts_i.clr_last) |=> (state_q == ST_IDLE))
    else $error("clear sweep did not return to idle");

  a_add_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD_RD) |=> (state_q == ST_ADD_WR) ##1 (state_q == ST_IDLE))
    else $error("add sequence broken");

endmodule

[rtl/weighted_histogram_quantile_interval_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_histogram_quantile_interval_unit
// Weighted histogram with tail and central quantile interval search.
// Add: the sample is latched on accept, then its bin is read and written back.
// Clear: sweeps every bin, one per cycle, through the single write port.
// Finish: threshold setup and the total beat, then the two tail walks and the
//   center walk, each reading one bin at a time, then the two center results;
//   five result beats.
// Reset: a clearing pass over all bins runs with busy_o high; results are
//   strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module weighted_histogram_quantile_interval_unit
  import whqi_pkg::*;
#(
  parameter int MAX_BINS     = 65536,
  parameter int BIN_SUM_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           operation_i,
  input  logic [31:0]          sample_value_i,
  input  logic [31:0]          sample_weight_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 result_valid_o,
  output logic [KIND_W-1:0]    kind_o,
  output logic [63:0]          result_value_o,
  output logic                 found_o,
  output logic                 last_o
);

  ctl_t ctl;
  sts_t sts;

  whqi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .busy_o      (busy_o),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  whqi_datapath #(
    .MAX_BINS     (MAX_BINS),
    .BIN_SUM_BITS (BIN_SUM_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_value_i  (sample_value_i),
    .sample_weight_i (sample_weight_i),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .result_value_o  (result_value_o),
    .found_o         (found_o),
    .last_o          (last_o)
  );

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == OP_FINISH) |=> busy_o)
    else $error("finish accepted but unit not busy");

  a_mid_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("non-final result beat while idle");

  a_total_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KIND_TOTAL) |-> found_o)
    else $error("total beat without found");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (result_value_o == '0))
    else $error("not-found beat carries a value");

endmodule

[verif/whqi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whqi_checker
// Watches the command, configuration and result ports of the weighted
// histogram quantile interval unit, keeps its own copy of the histogram and
// registers, predicts the five finish results and compares every result beat.
// ----------------------------------------------------------------------------
module whqi_checker
  import whqi_pkg::*;
#(
  parameter int MAX_BINS     = 65536,
  parameter int BIN_SUM_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [1:0]           operation_i,
  input  logic [31:0]          sample_value_i,
  input  logic [31:0]          sample_weight_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 result_valid_i,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [63:0]          result_value_i,
  input  logic                 found_i,
  input  logic                 last_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   finishes_o
);

  typedef struct {
    kind_e       kind;
    logic [63:0] value;
    logic        found;
    logic        last;
  } edge_beat_t;

  typedef logic signed [127:0] wide_t;

  logic [BIN_SUM_BITS-1:0] bin_mem [int];
  logic [63:0]             total_q;
  logic [30:0]             range_low_q;
  logic [16:0]             bin_count_q;
  logic [30:0]             center_q;
  logic [15:0]             coverage_q;
  edge_beat_t              interval_q [$];

  function automatic wide_t bin_at(longint unsigned i);
    logic [BIN_SUM_BITS-1:0] b;
    b = bin_mem.exists(int'(i)) ? bin_mem[int'(i)] : '0;
    return wide_t'($signed(b));
  endfunction

  function automatic longint unsigned bins_in_use();
    return (bin_count_q > MAX_BINS) ? MAX_BINS : bin_count_q;
  endfunction

  function automatic void push_beat(kind_e k, logic [63:0] v, logic ok, logic lst);
    edge_beat_t e;
    e.kind  = k;
    e.value = ok ? v : '0;
    e.found = ok;
    e.last  = lst;
    interval_q.push_back(e);
  endfunction

  function automatic void predict_intervals();
    longint unsigned n, i, c, a, b;
    logic [63:0]     rl, pos;
    wide_t           tot, tail_t, frac_t, acc;
    logic            ok, went_left;
    n      = bins_in_use();
    rl     = {33'd0, range_low_q};
    tot    = wide_t'($signed(total_q));
    tail_t = tot * (wide_t'(65536) - wide_t'({112'd0, coverage_q}));
    frac_t = tot * wide_t'({112'd0, coverage_q});
    push_beat(KIND_TOTAL, total_q, 1'b1, 1'b0);

    acc = '0; ok = 1'b0; pos = '0;
    for (i = 0; i < n; i++) begin
      acc = acc + bin_at(i);
      if (tail_t < (acc <<< 17)) begin
        ok = 1'b1; pos = rl + i; break;
      end
    end
    push_beat(KIND_TAIL_L, pos, ok, 1'b0);

    acc = '0; ok = 1'b0; pos = '0;
    for (i = n; i > 0; i--) begin
      acc = acc + bin_at(i - 1);
      if (tail_t < (acc <<< 17)) begin
        ok = 1'b1; pos = rl + i; break;
      end
    end
    push_beat(KIND_TAIL_R, pos, ok, 1'b0);

    c = {33'd0, center_q} - rl;
    went_left = 1'b1;
    ok = (center_q >= range_low_q) && (c < n);
    a = c;
    b = c;
    if (ok) begin
      acc = bin_at(c);
      while ((acc <<< 16) < frac_t) begin
        went_left = !went_left;
        if (went_left) begin
          if (a == 0) begin
            ok = 1'b0; break;
          end
          a--;
          acc = acc + bin_at(a);
        end else begin
          if (b + 1 >= n) begin
            ok = 1'b0; break;
          end
          b++;
          acc = acc + bin_at(b);
        end
      end
    end
    push_beat(KIND_CENT_L, rl + (went_left ? a + 1 : a), ok, 1'b0);
    push_beat(KIND_CENT_R, rl + (went_left ? b + 1 : b), ok, 1'b1);
  endfunction

  function automatic void apply_sample(logic [31:0] sv, logic [31:0] w);
    logic [63:0] idx;
    idx = {{32{sv[31]}}, sv} - {33'd0, range_low_q};
    if (idx < bins_in_use()) begin
      bin_mem[int'(idx)] = bin_at(idx) + {{96{w[31]}}, w};
      total_q = total_q + {{32{w[31]}}, w};
    end
  endfunction

  assign pending_o = interval_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    edge_beat_t e;
    if (!rst_ni) begin
      bin_mem.delete();
      interval_q.delete();
      total_q      = '0;
      range_low_q  = RANGE_LOW_RST;
      bin_count_q  = BIN_COUNT_RST;
      center_q     = CENTER_RST;
      coverage_q   = COVERAGE_RST;
      fail_count_o = 0;
      finishes_o   = 0;
    end else begin
      // compare first: a beat on this edge always belongs to an older command
      if (result_valid_i) begin
        if (interval_q.size() == 0) begin
          $error("result beat with nothing expected: kind %0d value %0d",
                 kind_i, $signed(result_value_i));
          fail_count_o++;
        end else begin
          e = interval_q.pop_front();
          if (kind_i !== e.kind) begin
            $error("kind: expected %0d, actual %0d", e.kind, kind_i);
            fail_count_o++;
          end
          if (result_value_i !== e.value) begin
            $error("result_value: expected %0d, actual %0d",
                   $signed(e.value), $signed(result_value_i));
            fail_count_o++;
          end
          if (found_i !== e.found) begin
            $error("found: expected %0b, actual %0b", e.found, found_i);
            fail_count_o++;
          end
          if (last_i !== e.last) begin
            $error("last: expected %0b, actual %0b", e.last, last_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_RANGE_LOW: range_low_q = cfg_data_i[30:0];
          REG_BIN_COUNT: bin_count_q = cfg_data_i[16:0];
          REG_CENTER:    center_q    = cfg_data_i[30:0];
          REG_COVERAGE:  coverage_q  = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        case (operation_i)
          OP_ADD:    apply_sample(sample_value_i, sample_weight_i);
          OP_FINISH: begin
            predict_intervals();
            finishes_o++;
          end
          OP_CLEAR: begin
            bin_mem.delete();
            total_q = '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[verif/weighted_histogram_quantile_interval_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_histogram_quantile_interval_unit_tb
// Directed edge cases (range limits, dropped samples, zero and clamped bin
// counts, seed outside range) followed by randomized phases of weighted
// samples into small windows with random finishes and register sets, plus one clear.
// ----------------------------------------------------------------------------
module weighted_histogram_quantile_interval_unit_tb;
  import whqi_pkg::*;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 30;
  // operation code with no meaning, ignored by the unit
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [1:0]           operation_i = OP_ADD;
  logic [31:0]          sample_value_i = '0;
  logic [31:0]          sample_weight_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 result_valid_o;
  logic [KIND_W-1:0]    kind_o;
  logic [63:0]          result_value_o;
  logic                 found_o;
  logic                 last_o;
  int                   fail_count;
  int                   pending;
  int                   finishes;
  int                   items_sent;
  int                   quiet_cycles;
  logic [30:0]          win_low;
  logic [16:0]          win_bins;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  weighted_histogram_quantile_interval_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .sample_value_i,
    .sample_weight_i, .cfg_we_i, .cfg_index_i, .cfg_data_i, .result_valid_o,
    .kind_o, .result_value_o, .found_o, .last_o
  );

  whqi_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i, .sample_value_i,
    .sample_weight_i, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .result_valid_i(result_valid_o), .kind_i(kind_o), .result_value_i(result_value_o),
    .found_i(found_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending), .finishes_o(finishes)
  );

  // count cycles in which neither a command nor a result beat moves
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // leaves start high on the accepting edge so a back-to-back beat needs no toggle
  task automatic send(logic [1:0] op, logic [31:0] sv, logic [31:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    operation_i     <= op;
    sample_value_i  <= sv;
    sample_weight_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o || pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [30:0] rl, logic [16:0] bc, logic [30:0] cv,
                              logic [15:0] cov);
    cfg_we_i <= 1'b1; cfg_index_i <= REG_RANGE_LOW; cfg_data_i <= rl;
    @(posedge clk_i);
    cfg_index_i <= REG_BIN_COUNT; cfg_data_i <= 31'(bc);
    @(posedge clk_i);
    cfg_index_i <= REG_CENTER; cfg_data_i <= cv;
    @(posedge clk_i);
    cfg_index_i <= REG_COVERAGE; cfg_data_i <= 31'(cov);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    win_low  = rl;
    win_bins = bc;
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 262144)) - 131072);
      default: return 32'($urandom_range(1, 300000));
    endcase
  endfunction

  task automatic run_phase(int idx);
    logic [30:0] rl;
    logic [16:0] bc;
    logic [30:0] cv;
    logic [15:0] cov;
    int          r;
    case ($urandom_range(0, 4))
      0:       rl = 31'h7FFF_FFFF - 31'($urandom_range(0, 20));
      1:       rl = 31'($urandom());
      2:       rl = '0;
      default: rl = 31'($urandom_range(0, 5000));
    endcase
    bc  = ($urandom_range(0, 9) == 0) ? 17'd0 : 17'($urandom_range(1, 16));
    r   = $urandom_range(0, 9);
    if (r == 0)      cv = 31'($urandom());
    else if (r == 1) cv = rl - 31'd1;
    else             cv = rl + 31'($urandom_range(0, 17));
    case ($urandom_range(0, 3))
      0:       cov = 16'd0;
      1:       cov = 16'hFFFF;
      default: cov = 16'($urandom());
    endcase
    program_regs(rl, bc, cv, cov);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      if (k == PHASE_ITEMS - 1 || r < 8)
        send(OP_FINISH, $urandom(), $urandom());
      else if (r < 80)
        send(OP_ADD, 32'(win_low) + 32'($urandom_range(0, win_bins)), pick_weight());
      else if (r < 93)
        send(OP_ADD, $urandom(), $urandom());
      else if (r < 97)
        send(OP_UNUSED, $urandom(), $urandom());
      else
        send(OP_ADD, 32'(win_low) - 32'd1, pick_weight());
    end
    // one clear mid-run; each costs a full sweep of the bin memory
    if (idx == PHASES / 2) send(OP_CLEAR, $urandom(), $urandom());
    drain();
  endtask

  initial begin
    items_sent   = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // reset window 105000..159999, seed at 125000
    send(OP_ADD, 32'd125000, 32'h0001_0000);
    send(OP_ADD, 32'd105000, 32'h7FFF_FFFF);
    send(OP_ADD, 32'd159999, 32'h8000_0000);
    send(OP_ADD, 32'd104999, 32'h0001_0000);
    send(OP_ADD, 32'd160000, 32'h0001_0000);
    send(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
    send(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    send(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_FINISH, '0, '0);
    send(OP_CLEAR, '0, '0);
    drain();

    // zero bins: samples drop, every search misses
    program_regs(31'd0, 17'd0, 31'd0, 16'hFFFF);
    send(OP_ADD, 32'd0, 32'h0001_0000);
    send(OP_FINISH, '0, '0);
    drain();

    // bin count above the memory size clamps; seed below the window
    program_regs(31'h7FFF_FFFF, 17'h1FFFF, 31'd0, 16'hFFFF);
    send(OP_ADD, 32'h7FFF_FFFF, 32'h0002_0000);
    send(OP_FINISH, '0, '0);
    drain();

    // tail and center walks over a tiny window holding a negative bin
    program_regs(31'd0, 17'd3, 31'd1, 16'hFFFF);
    send(OP_ADD, 32'd1, 32'h0001_0000);
    send(OP_ADD, 32'd0, 32'hFFFF_0000);
    send(OP_ADD, 32'd2, 32'h0003_0000);
    send(OP_FINISH, '0, '0);
    send(OP_ADD, 32'd1, 32'h0100_0000);
    send(OP_FINISH, '0, '0);
    drain();

    for (int p = 0; p < PHASES; p++) run_phase(p);

    repeat (10) @(posedge clk_i);
    $display("Run covered %0d commands and %0d finish result sets over %0d phases",
             items_sent, finishes, PHASES);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/whqi_pkg.sv
rtl/whqi_ram.sv
rtl/whqi_datapath.sv
rtl/whqi_ctrl.sv
rtl/weighted_histogram_quantile_interval_unit.sv
verif/whqi_checker.sv
verif/weighted_histogram_quantile_interval_unit_tb.sv
